[rtl/tcs_pkg.sv]
// tcs_pkg: shared types and constants of the tick-driven cpu scheduler
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package tcs_pkg;

  localparam int TASK_ID_W = 3;
  localparam int PRIO_W    = 4;
  localparam int BURST_W   = 8;
  localparam int TIME_W    = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam logic MODE_FCFS = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_SCAN,
    S_INSERT,
    S_DISPATCH,
    S_RUN
  } state_t;

  typedef struct packed {
    logic take;
    logic arr_start;
    logic scan_step;
    logic insert;
    logic dispatch;
    logic run;
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic arr_ok;
    logic direct_ins;
    logic scan_more;
    logic out_full;
  } sts_t;

endpackage

`default_nettype wire

[rtl/tcs_in_if.sv]
// tcs_in_if: input channel of the scheduler, one beat per arrival or tick
// depends on tcs_pkg for field widths
`default_nettype none

interface tcs_in_if import tcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [TASK_ID_W-1:0] task_id;
  logic [PRIO_W-1:0]    task_priority;
  logic [BURST_W-1:0]   burst_length;

  modport source (output valid, cmd, task_id, task_priority, burst_length, input ready);
  modport sink   (input valid, cmd, task_id, task_priority, burst_length, output ready);
endinterface

`default_nettype wire

[rtl/tcs_out_if.sv]
// tcs_out_if: result channel of the scheduler, one beat per tick
// depends on tcs_pkg for field widths
`default_nettype none

interface tcs_out_if import tcs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 busy_res;
  logic [TASK_ID_W-1:0] ran_task;
  logic                 finished;
  logic [TIME_W-1:0]    finish_time;
  logic [TIME_W-1:0]    slot_number;

  modport source (output valid, busy_res, ran_task, finished, finish_time, slot_number,
                  input ready);
  modport sink   (input valid, busy_res, ran_task, finished, finish_time, slot_number,
                  output ready);
endinterface

`default_nettype wire

[rtl/tcs_ctrl.sv]
// tcs_ctrl: sequencer of the scheduler, steps arrivals and ticks through the datapath
// depends on tcs_pkg for the state, command and status types
`default_nettype none

module tcs_ctrl import tcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_nxt  = S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        if (sts_i.is_tick) begin
          state_nxt = S_DISPATCH;
        end else if (!sts_i.arr_ok) begin
          state_nxt = S_IDLE;
        end else begin
          cmd_o.arr_start = 1'b1;
          state_nxt       = sts_i.direct_ins ? S_INSERT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd_o.insert = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DISPATCH: begin
        if (!sts_i.out_full) begin
          cmd_o.dispatch = 1'b1;
          state_nxt      = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/tcs_dpath.sv]
// tcs_dpath: task stores, ready queue, running slot, tick counter and result register
// depends on tcs_pkg; driven by tcs_ctrl through cmd_t, reports through sts_t
`default_nettype none

module tcs_dpath import tcs_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic                 policy_i,
  input  logic                 in_cmd_i,
  input  logic [TASK_ID_W-1:0] in_task_id_i,
  input  logic [PRIO_W-1:0]    in_task_priority_i,
  input  logic [BURST_W-1:0]   in_burst_length_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_busy_res_o,
  output logic [TASK_ID_W-1:0] out_ran_task_o,
  output logic                 out_finished_o,
  output logic [TIME_W-1:0]    out_finish_time_o,
  output logic [TIME_W-1:0]    out_slot_number_o
);

  localparam int IDW = $clog2(NUM_TASKS);
  localparam int CW  = $clog2(NUM_TASKS + 1);

  // latched beat
  logic                 item_cmd_r;
  logic [TASK_ID_W-1:0] item_id_r;
  logic [PRIO_W-1:0]    item_prio_r;
  logic [BURST_W-1:0]   item_burst_r;

  // task stores and queue
  logic [IDW-1:0]     order_r [NUM_TASKS];
  logic [PRIO_W-1:0]  prio_r  [NUM_TASKS];
  logic [BURST_W-1:0] burst_r [NUM_TASKS];
  logic [BURST_W-1:0] prog_r  [NUM_TASKS];

  logic [NUM_TASKS-1:0] pending_r;
  logic [CW-1:0]        count_r;
  logic [IDW-1:0]       run_id_r;
  logic                 run_vld_r;
  logic [TIME_W-1:0]    tick_r;
  logic [CW-1:0]        pos_r;
  logic [IDW-1:0]       ins_id_r;

  logic                 out_valid_r;
  logic                 out_busy_r;
  logic [TASK_ID_W-1:0] out_ran_r;
  logic                 out_fin_r;
  logic [TIME_W-1:0]    out_ftime_r;
  logic [TIME_W-1:0]    out_slot_r;

  logic [IDW-1:0]     id_idx;
  logic               id_in_range;
  logic [IDW-1:0]     scan_idx;
  logic [PRIO_W-1:0]  prio_run;
  logic [PRIO_W-1:0]  prio_scan;
  logic               preempt;
  logic [BURST_W-1:0] prog_nxt;
  logic               fin_w;
  logic [TIME_W-1:0]  tick_nxt;

  assign id_idx      = IDW'(item_id_r);
  assign id_in_range = int'(item_id_r) < NUM_TASKS;
  assign scan_idx    = pos_r[IDW-1:0];
  assign prio_run    = prio_r[run_id_r];
  assign prio_scan   = prio_r[order_r[scan_idx]];
  assign preempt     = (policy_i == MODE_PRIO) && run_vld_r && (item_prio_r < prio_run);
  assign prog_nxt    = prog_r[run_id_r] + BURST_W'(1);
  assign fin_w       = prog_nxt >= burst_r[run_id_r];
  assign tick_nxt    = tick_r + TIME_W'(1);

  always_comb begin
    sts_o.is_tick    = item_cmd_r == CMD_TICK;
    sts_o.arr_ok     = id_in_range && !pending_r[id_idx];
    sts_o.direct_ins = (policy_i == MODE_FCFS) || preempt;
    sts_o.scan_more  = (pos_r < count_r) && (prio_scan < item_prio_r);
    sts_o.out_full   = out_valid_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      count_r     <= '0;
      run_id_r    <= '0;
      run_vld_r   <= 1'b0;
      tick_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.arr_start) begin
        pending_r[id_idx] <= 1'b1;
        if (preempt) begin
          run_id_r <= id_idx;
        end
      end
      if (cmd_i.insert) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd_i.dispatch) begin
        tick_r <= tick_nxt;
        if (!run_vld_r && (count_r != '0)) begin
          run_id_r  <= order_r[0];
          run_vld_r <= 1'b1;
          count_r   <= count_r - CW'(1);
        end
      end
      if (cmd_i.run && run_vld_r && fin_w) begin
        pending_r[run_id_r] <= 1'b0;
        run_vld_r           <= 1'b0;
        run_id_r            <= '0;
      end
      if (cmd_i.run) begin
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd_i.take) begin
      item_cmd_r   <= in_cmd_i;
      item_id_r    <= in_task_id_i;
      item_prio_r  <= in_task_priority_i;
      item_burst_r <= in_burst_length_i;
    end
    if (cmd_i.arr_start) begin
      prio_r[id_idx]  <= item_prio_r;
      burst_r[id_idx] <= item_burst_r;
      prog_r[id_idx]  <= '0;
      if (policy_i == MODE_FCFS) begin
        pos_r    <= count_r;
        ins_id_r <= id_idx;
      end else if (preempt) begin
        pos_r    <= '0;
        ins_id_r <= run_id_r;
      end else begin
        pos_r    <= '0;
        ins_id_r <= id_idx;
      end
    end
    if (cmd_i.scan_step) begin
      pos_r <= pos_r + CW'(1);
    end
    if (cmd_i.run) begin
      if (run_vld_r) begin
        prog_r[run_id_r] <= prog_nxt;
      end
      out_busy_r  <= run_vld_r;
      out_ran_r   <= run_vld_r ? TASK_ID_W'(run_id_r) : '0;
      out_fin_r   <= run_vld_r && fin_w;
      out_ftime_r <= (run_vld_r && fin_w) ? tick_nxt : '0;
      out_slot_r  <= tick_r;
    end
  end

  // ready queue: shift up on insert, shift down on pop
  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_queue
    always_ff @(posedge clk) begin
      if (cmd_i.insert) begin
        if (CW'(k) == pos_r) begin
          order_r[k] <= ins_id_r;
        end else if (CW'(k) > pos_r) begin
          if (k > 0) begin
            order_r[k] <= order_r[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (cmd_i.dispatch && !run_vld_r && (count_r != '0)) begin
        if (k < NUM_TASKS - 1) begin
          order_r[k] <= order_r[(k < NUM_TASKS - 1) ? k + 1 : k];
        end
      end
    end
  end

  assign out_valid_o       = out_valid_r;
  assign out_busy_res_o    = out_busy_r;
  assign out_ran_task_o    = out_ran_r;
  assign out_finished_o    = out_fin_r;
  assign out_finish_time_o = out_ftime_r;
  assign out_slot_number_o = out_slot_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) + int'(run_vld_r) <= NUM_TASKS)
    else $error("ready queue overfull");

  a_running_pending: assert property (@(posedge clk) disable iff (!rst_n)
    run_vld_r |-> pending_r[run_id_r])
    else $error("running task not pending");

  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.run && run_vld_r && fin_w |=> !run_vld_r && !pending_r[$past(run_id_r)])
    else $error("finished task still held");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd_i.run))
    else $error("result beat without a run step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.dispatch |-> !out_valid_r)
    else $error("tick dispatched while result beat waits");

endmodule

`default_nettype wire

[rtl/tick_cpu_scheduler_fcfs_priority.sv]
// tick_cpu_scheduler_fcfs_priority: top level, apb policy register, controller and datapath
// depends on tcs_pkg, tcs_in_if, tcs_out_if, tcs_ctrl and tcs_dpath
//
// channel  dir  beat
// in_if    in   arrival (task_id, task_priority, burst_length) or tick, by cmd
// out_if   out  one result per tick: busy_res, ran_task, finished, finish_time, slot_number
// cfg_*    in   apb, policy_mode at byte address 0
//
// tick: steps accept, decode, dispatch, run; dispatch waits while the result register is full
// arrival: accept, decode if ignored; accept, decode, insert in fcfs mode or on preemption;
//   accept, decode, scan, insert in priority mode, the scan stepping over the queue entries ahead
// one beat is worked at a time; the result register lets the next beat in while out_if stalls
// a tick waits in dispatch until the previous result beat has gone
// reset is synchronous; no clearing pass, stores are written before use
`default_nettype none

module tick_cpu_scheduler_fcfs_priority import tcs_pkg::*; #(
  parameter int NUM_TASKS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  tcs_in_if.sink            in_if,
  tcs_out_if.source         out_if,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic policy_r;
  logic cfg_wr;
  logic cfg_hit;
  cmd_t cmd;
  sts_t sts;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[2] == REG_POLICY;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_hit ? APB_DW'(policy_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= MODE_FCFS;
    end else if (cfg_wr && cfg_hit) begin
      policy_r <= cfg_pwdata[0];
    end
  end

  tcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcs_dpath #(
    .NUM_TASKS (NUM_TASKS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .policy_i           (policy_r),
    .in_cmd_i           (in_if.cmd),
    .in_task_id_i       (in_if.task_id),
    .in_task_priority_i (in_if.task_priority),
    .in_burst_length_i  (in_if.burst_length),
    .out_valid_o        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_busy_res_o     (out_if.busy_res),
    .out_ran_task_o     (out_if.ran_task),
    .out_finished_o     (out_if.finished),
    .out_finish_time_o  (out_if.finish_time),
    .out_slot_number_o  (out_if.slot_number)
  );

endmodule

`default_nettype wire

[test/tick_cpu_scheduler_fcfs_priority_tb.sv]
`timescale 1ns / 100ps
// tick_cpu_scheduler_fcfs_priority_tb: self-checking bench for the tick-driven scheduler
// directed table then random phases under both policies, checked against a local predictor
// depends on tcs_pkg, tcs_in_if, tcs_out_if and the top level of the block

module tick_cpu_scheduler_fcfs_priority_tb;
  import tcs_pkg::*;

  localparam int NUM_TASKS    = 8;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 290;
  localparam int SETTLE_CYC   = 24;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic              busy;
    logic [TASK_ID_W-1:0] ran;
    logic              fin;
    logic [TIME_W-1:0] ftime;
    logic [TIME_W-1:0] slot;
  } slot_res_t;

  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_MODE
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 mode;
    logic                 cmd;
    logic [TASK_ID_W-1:0] id;
    logic [PRIO_W-1:0]    prio;
    logic [BURST_W-1:0]   burst;
    logic                 typed;
    slot_res_t            want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  tcs_in_if  in_ch ();
  tcs_out_if out_ch ();

  tick_cpu_scheduler_fcfs_priority #(
    .NUM_TASKS (NUM_TASKS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // scheduler state as predicted
  logic                 model_mode = MODE_FCFS;
  logic [TASK_ID_W-1:0] ready_ids[$];
  logic [TASK_ID_W-1:0] run_id = '0;
  logic                 run_valid = 1'b0;
  logic [PRIO_W-1:0]    prio_tab[NUM_TASKS];
  logic [BURST_W-1:0]   burst_tab[NUM_TASKS];
  logic [BURST_W-1:0]   prog_tab[NUM_TASKS];
  logic                 pend[NUM_TASKS] = '{default: 1'b0};
  logic [TIME_W-1:0]    ticks = '0;

  slot_res_t want_q[$];

  int errs = 0;
  int n_arr = 0;
  int n_tick = 0;
  int n_ignored = 0;
  int n_preempt = 0;
  int n_writes = 0;
  int n_checked = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int cyc = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cyc, want_q.size());
    $display("tick_cpu_scheduler_fcfs_priority_tb: done, errors");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want_v);
    if (errs < PRINT_CAP)
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want_v, cyc);
    errs++;
  endtask

  task automatic model_beat(input logic c, input logic [TASK_ID_W-1:0] id,
                            input logic [PRIO_W-1:0] pr, input logic [BURST_W-1:0] bl,
                            output bit effective, output bit has_res, output slot_res_t res);
    int pos;
    effective = 1'b1;
    has_res   = 1'b0;
    res       = '0;
    if (c == CMD_ARRIVE) begin
      n_arr++;
      if (pend[id]) begin
        effective = 1'b0;
        n_ignored++;
      end else begin
        prio_tab[id]  = pr;
        burst_tab[id] = bl;
        prog_tab[id]  = '0;
        pend[id]      = 1'b1;
        if (model_mode == MODE_FCFS) begin
          ready_ids.push_back(id);
        end else if (run_valid && pr < prio_tab[run_id]) begin
          ready_ids.push_front(run_id);
          run_id = id;
          n_preempt++;
        end else begin
          pos = 0;
          while (pos < ready_ids.size() && prio_tab[ready_ids[pos]] < pr)
            pos++;
          ready_ids.insert(pos, id);
        end
      end
    end else begin
      n_tick++;
      has_res = 1'b1;
      ticks   = ticks + 1'b1;
      if (!run_valid && ready_ids.size() > 0) begin
        run_id    = ready_ids.pop_front();
        run_valid = 1'b1;
      end
      if (run_valid) begin
        res.busy = 1'b1;
        res.ran  = run_id;
        prog_tab[run_id] = prog_tab[run_id] + 1'b1;
        if (prog_tab[run_id] >= burst_tab[run_id]) begin
          res.fin   = 1'b1;
          res.ftime = ticks + 1'b1;
          pend[run_id] = 1'b0;
          run_valid = 1'b0;
          run_id    = '0;
        end
      end
      res.slot = ticks;
    end
  endtask

  // offers one beat, predicts on acceptance, then maybe opens a gap
  task automatic push_beat(input logic c, input logic [TASK_ID_W-1:0] id,
                           input logic [PRIO_W-1:0] pr, input logic [BURST_W-1:0] bl,
                           input logic typed, input slot_res_t typed_res, output bit effective);
    bit        has_res;
    slot_res_t res;
    int        gap;
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= c;
    in_ch.task_id       <= id;
    in_ch.task_priority <= pr;
    in_ch.burst_length  <= bl;
    do @(posedge clk); while (!in_ch.ready);
    model_beat(c, id, pr, bl, effective, has_res, res);
    if (has_res)
      want_q.push_back(typed ? typed_res : res);
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (want_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {REG_POLICY, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_policy(input logic mode);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, {{(APB_DW-1){1'b0}}, mode}, rd);
    model_mode = mode;
    n_writes++;
    apb_access(1'b0, '0, rd);
    if (rd != {{(APB_DW-1){1'b0}}, mode})
      report_mismatch("policy readback", rd, mode);
  endtask

  // result side: stall pattern redrawn after each random span, plus one long hold
  initial begin
    int stall_pct;
    int span;
    int hold_left;
    int hold_seen;
    out_ch.ready = 1'b0;
    stall_pct = 0;
    span      = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 60;
            default: stall_pct = 95;
          endcase
        end
        span--;
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    slot_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (want_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding, slot", out_ch.slot_number, 0);
      end else begin
        want = want_q.pop_front();
        if (out_ch.busy_res !== want.busy)
          report_mismatch("busy_res", out_ch.busy_res, want.busy);
        if (out_ch.ran_task !== want.ran)
          report_mismatch("ran_task", out_ch.ran_task, want.ran);
        if (out_ch.finished !== want.fin)
          report_mismatch("finished", out_ch.finished, want.fin);
        if (out_ch.finish_time !== want.ftime)
          report_mismatch("finish_time", out_ch.finish_time, want.ftime);
        if (out_ch.slot_number !== want.slot)
          report_mismatch("slot_number", out_ch.slot_number, want.slot);
      end
    end
  end

  initial begin
    dir_row_t             dir_tab[$];
    logic [TASK_ID_W-1:0] free_ids[$];
    logic [APB_DW-1:0]    rd;
    logic [TASK_ID_W-1:0] rid;
    logic [PRIO_W-1:0]    rpr;
    logic [BURST_W-1:0]   rbl;
    bit                   eff;
    bit                   held;
    int                   done_n;
    int                   npend;
    int                   tick_pct;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_ARRIVE;
    in_ch.task_id       = '0;
    in_ch.task_priority = '0;
    in_ch.burst_length  = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    held                = 1'b0;

    // first come first served from reset
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b1,
                        {1'b0, 3'd0, 1'b0, 16'd0, 16'd1}});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd0, 4'd0, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b1,
                        {1'b1, 3'd0, 1'b1, 16'd3, 16'd2}});
    // zero burst finishes after one slot
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd7, 4'd15, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd7, 4'd15, 8'd255, 1'b1,
                        {1'b1, 3'd7, 1'b1, 16'd4, 16'd3}});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd3, 4'd5, 8'd2, 1'b0, '0});
    // already pending, dropped
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd3, 4'd1, 8'd9, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd5, 4'd0, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    // priority: preemption, sorted insert, tie goes ahead of equal
    dir_tab.push_back('{ROW_MODE, MODE_PRIO, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd2, 4'd8, 8'd3, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd4, 4'd3, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd6, 4'd15, 8'd255, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd1, 4'd8, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd2, 4'd0, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    // policy flip with a task still queued
    dir_tab.push_back('{ROW_MODE, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_ARRIVE, 3'd0, 4'd0, 8'd1, 1'b0, '0});
    dir_tab.push_back('{ROW_BEAT, MODE_FCFS, CMD_TICK, 3'd0, 4'd0, 8'd0, 1'b0, '0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apb_access(1'b0, '0, rd);
    if (rd != {{(APB_DW-1){1'b0}}, MODE_FCFS})
      report_mismatch("policy after reset", rd, MODE_FCFS);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind == ROW_MODE) begin
        settle();
        set_policy(dir_tab[r].mode);
      end else begin
        push_beat(dir_tab[r].cmd, dir_tab[r].id, dir_tab[r].prio, dir_tab[r].burst,
                  dir_tab[r].typed, dir_tab[r].want, eff);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      set_policy((ph % 2 == 0) ? MODE_PRIO : MODE_FCFS);
      done_n = 0;
      while (done_n < PHASE_ITEMS) begin
        if (ph == 1 && done_n >= 120 && !held) begin
          held = 1'b1;
          hold_asks <= hold_asks + 1;
        end
        free_ids.delete();
        npend = 0;
        for (int k = 0; k < NUM_TASKS; k++) begin
          if (pend[k])
            npend++;
          else
            free_ids.push_back(k[TASK_ID_W-1:0]);
        end
        tick_pct = (npend == 0) ? 25 : ((npend == NUM_TASKS) ? 85 : 50);
        rid = TASK_ID_W'($urandom_range(0, NUM_TASKS - 1));
        rpr = PRIO_W'($urandom_range(0, 15));
        rbl = BURST_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < tick_pct) begin
          push_beat(CMD_TICK, rid, rpr, rbl, 1'b0, '0, eff);
        end else begin
          // mostly fresh tasks with short bursts, some re-arrivals of busy ids
          if (free_ids.size() > 0 && $urandom_range(0, 4) != 0)
            rid = free_ids[$urandom_range(0, free_ids.size() - 1)];
          if ($urandom_range(0, 2) == 0)
            rpr = PRIO_W'($urandom_range(6, 9));
          if ($urandom_range(0, 49) != 0)
            rbl = BURST_W'($urandom_range(0, 6));
          push_beat(CMD_ARRIVE, rid, rpr, rbl, 1'b0, '0, eff);
        end
        if (eff)
          done_n++;
      end
    end

    settle();
    $display("covered %0d arrivals (%0d dropped as pending), %0d ticks, %0d preemptions",
             n_arr, n_ignored, n_tick, n_preempt);
    $display("%0d policy writes, %0d result beats checked, %0d mismatches",
             n_writes, n_checked, errs);
    if (errs == 0)
      $display("tick_cpu_scheduler_fcfs_priority_tb: done, clean");
    else
      $display("tick_cpu_scheduler_fcfs_priority_tb: done, errors");
    $finish;
  end

endmodule
